// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, command and status codes, and the request and result beat types.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NAME_BYTES  = 25;

    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int NAME_PORT_B = 25;
    localparam int NAME_FULL_W = NAME_PORT_B * 8;
    localparam int NAME_KEEP   = (NAME_BYTES < NAME_PORT_B) ? NAME_BYTES : NAME_PORT_B;
    localparam int NAME_W      = NAME_KEEP * 8;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_PEEK_BACK  = 3'd4,
        CMD_PEEK_FRONT = 3'd5
    } command_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] in_id_number;
        logic [31:0] in_record_code;
        logic [63:0] in_name_bytes_0_7;
        logic [63:0] in_name_bytes_8_15;
        logic [63:0] in_name_bytes_16_23;
        logic [7:0]  in_name_byte_24;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_id_number;
        logic [31:0]        out_record_code;
        logic [63:0]        out_name_bytes_0_7;
        logic [63:0]        out_name_bytes_8_15;
        logic [63:0]        out_name_bytes_16_23;
        logic [7:0]         out_name_byte_24;
        logic [COUNT_W-1:0] occupancy;
    } result_t;

endpackage

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded ring of records with push, pop and peek at either end.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A push, a refused
// command or an unused code answers with a done strobe in the next cycle, so
// one such beat can follow another every cycle. A pop or peek reads the
// record memory, whose read port is registered: busy is high for one cycle,
// and the done strobe comes from the read-data register through the result
// register. The done strobe is shown for exactly one cycle and the result
// must be taken then, as the receiver cannot hold it off. The record memory
// needs no clearing after reset.
module double_ended_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  deq_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output deq_pkg::result_t   result
);
    import deq_pkg::*;

    typedef struct packed {
        logic [31:0]       id;
        logic [31:0]       code;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [IDX_W-1:0]   back_reg, back_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    entry_t             mem [QUEUE_DEPTH];
    entry_t             rd_data_reg;
    entry_t             wr_data;
    logic [IDX_W-1:0]   slot;
    logic               wr_en;
    logic               rd_en;
    logic               accept;
    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [IDX_W-1:0]   back_dec;
    logic [IDX_W-1:0]   back_inc;
    logic [NAME_FULL_W-1:0] name_in;
    logic [NAME_FULL_W-1:0] name_out;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
    endfunction

    assign busy      = (state_reg == S_READ);
    assign accept    = start && !busy;
    assign full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = ring_dec(front_reg);
    assign front_inc = ring_inc(front_reg);
    assign back_dec  = ring_dec(back_reg);
    assign back_inc  = ring_inc(back_reg);
    assign done      = done_reg;
    assign result    = result_reg;

    assign name_in = {request.in_name_byte_24, request.in_name_bytes_16_23,
                      request.in_name_bytes_8_15, request.in_name_bytes_0_7};
    assign name_out = NAME_FULL_W'(rd_data_reg.name);

    always_comb
    begin
        wr_data.id   = request.in_id_number;
        wr_data.code = request.in_record_code;
        wr_data.name = name_in[NAME_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        slot        = front_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next             = 1'b1;
                    result_next           = '0;
                    result_next.status    = STATUS_DONE;
                    result_next.occupancy = count_reg;
                    case (request.command) inside
                        CMD_PUSH_BACK, CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en                 = 1'b1;
                                count_next            = count_reg + 1'b1;
                                result_next.occupancy = count_reg + 1'b1;
                                if (request.command == CMD_PUSH_BACK)
                                begin
                                    slot      = back_reg;
                                    back_next = back_inc;
                                end
                                else
                                begin
                                    slot       = front_dec;
                                    front_next = front_dec;
                                end
                            end
                        end
                        CMD_POP_BACK, CMD_POP_FRONT, CMD_PEEK_BACK, CMD_PEEK_FRONT:
                        begin
                            if (empty)
                            begin
                                result_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                done_next  = 1'b0;
                                state_next = S_READ;
                                case (request.command)
                                    CMD_POP_BACK:
                                    begin
                                        slot       = back_dec;
                                        back_next  = back_dec;
                                        count_next = count_reg - 1'b1;
                                    end
                                    CMD_POP_FRONT:
                                    begin
                                        slot       = front_reg;
                                        front_next = front_inc;
                                        count_next = count_reg - 1'b1;
                                    end
                                    CMD_PEEK_BACK:
                                    begin
                                        slot = back_dec;
                                    end
                                    default:
                                    begin
                                        slot = front_reg;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next                        = 1'b1;
                state_next                       = S_IDLE;
                result_next.status               = STATUS_DONE;
                result_next.out_id_number        = rd_data_reg.id;
                result_next.out_record_code      = rd_data_reg.code;
                result_next.out_name_bytes_0_7   = name_out[63:0];
                result_next.out_name_bytes_8_15  = name_out[127:64];
                result_next.out_name_bytes_16_23 = name_out[191:128];
                result_next.out_name_byte_24     = name_out[199:192];
                result_next.occupancy            = count_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot];
        end
    end

`ifndef SYNTHESIS
    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("Memory read did not complete in one cycle.");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STATUS_FULL) |->
        result.occupancy == COUNT_W'(QUEUE_DEPTH))
        else $error("Full status reported with a queue that is not full.");

    a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STATUS_EMPTY) |-> result.occupancy == '0)
        else $error("Empty status reported with records held.");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && ((request.command == CMD_PUSH_BACK) ||
        (request.command == CMD_PUSH_FRONT)) |=>
        done && (result.occupancy == $past(count_reg) + 1'b1))
        else $error("Accepted push did not raise the occupancy by one.");
`endif

endmodule
